[sv/spe_pkg.sv]
// Shared types, constants and rounding helper for the segment prism expander.
package spe_pkg;

  localparam logic [31:0] THRESH_09 = 32'd966367642;
  localparam logic signed [32:0] K_0866 = 33'sd929860420;
  localparam logic [30:0] RADIUS_RST = 31'd655;
  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_START = 2'd1;
  localparam logic [3:0] NUM_REC = 4'd12;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_NORM, S_SQ, S_SQRT, S_DIVI, S_DIV,
    S_AXIS, S_CROSS, S_CORN, S_OFF, S_EMIT
  } spe_state_t;

  // round(x / 2^30), halves away from zero
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    m = x[63] ? 64'(-x) : 64'(x);
    r = (m + 64'd536870912) >> 30;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

[sv/spe_if.sv]
// Channel interfaces: segment input, record output and configuration write.
interface spe_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface spe_out_if;
  logic valid;
  logic ready;
  logic record_type;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [31:0] corner0, corner1, corner2;
  logic last;
  modport source (output valid, record_type, pos_x, pos_y, pos_z, corner0, corner1,
                  corner2, last, input ready);
  modport sink (input valid, record_type, pos_x, pos_y, pos_z, corner0, corner1,
                corner2, last, output ready);
endinterface

interface spe_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/segment_prism_expander.sv]
// Segment prism expander top level: sequencer around one shared multiplier.
//
//  channel  | dir | word
//  ---------+-----+----------------------------------------------
//  in_ch    | in  | segment endpoints a, b (Q16.16)
//  out_ch   | out | vertex or triangle record, twelve per segment
//  cfg_ch   | in  | register index and write data, always ready
//
// After a segment is accepted, up to 30 normalize shifts, two 32-step square roots
// and five 31-step divides run before the first record.
// Records then leave one per cycle while out_ch is ready.
// rst_n is synchronous; it clears the sequencer, configuration registers and vertex counter.
// in_ch is ready only while idle; a stalled last record does not block it.
// A zero-length segment returns to idle with no records.
module segment_prism_expander (
  input logic clk,
  input logic rst_n,
  spe_in_if.sink in_ch,
  spe_out_if.source out_ch,
  spe_cfg_if.sink cfg_ch
);
  import spe_pkg::*;

  spe_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [4:0] it_r, it_nxt;
  logic [1:0] k_r, k_nxt;
  logic ph_r, ph_nxt;
  logic yaxis_r, yaxis_nxt;
  logic [3:0] rec_r, rec_nxt;

  logic [30:0] radius_r;
  logic [31:0] start_r, vcount_r, vcount_nxt;

  logic signed [31:0] a_r [3], a_nxt [3], b_r [3], b_nxt [3];
  logic [31:0] mag_r [3], mag_nxt [3];
  logic neg_r [3], neg_nxt [3];
  logic [63:0] acc_r, acc_nxt, n_r, n_nxt, res_r, res_nxt;
  logic [31:0] len_r, len_nxt, rem_r, rem_nxt;
  logic [30:0] sh_r, sh_nxt, quot_r, quot_nxt;
  logic signed [31:0] dir_r [3], dir_nxt [3], u_r [3], u_nxt [3], v_r [3], v_nxt [3];
  logic signed [31:0] corf_r [9], corf_nxt [9];
  logic [31:0] off_r [9], off_nxt [9];

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  logic out_valid_r, out_valid_nxt, out_type_r, out_type_nxt, out_last_r, out_last_nxt;
  logic signed [31:0] out_pos_r [3], out_pos_nxt [3];
  logic [31:0] out_c_r [3], out_c_nxt [3];

  logic signed [32:0] dd [3];
  logic [32:0] dm [3];
  logic [31:0] mmax;
  logic [3:0] nsq;
  logic [63:0] bitv, sum_rb;
  logic [61:0] num;
  logic [32:0] t;
  logic ge;
  logic [30:0] qv;
  logic signed [31:0] qs, ax, s0, s1;
  logic [2:0] j3;
  logic [1:0] j2;
  logic signed [63:0] half, prod64, c1, c2;
  logic load;
  logic [1:0] ci, ts, tn;
  logic [3:0] obase, tr;
  logic [31:0] base;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.record_type = out_type_r;
  assign out_ch.pos_x = out_pos_r[0];
  assign out_ch.pos_y = out_pos_r[1];
  assign out_ch.pos_z = out_pos_r[2];
  assign out_ch.corner0 = out_c_r[0];
  assign out_ch.corner1 = out_c_r[1];
  assign out_ch.corner2 = out_c_r[2];
  assign out_ch.last = out_last_r;

  assign prod64 = prod_r[63:0];

  always_comb begin
    mmax = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    it_nxt = it_r;
    k_nxt = k_r;
    ph_nxt = ph_r;
    yaxis_nxt = yaxis_r;
    rec_nxt = rec_r;
    vcount_nxt = vcount_r;
    a_nxt = a_r;
    b_nxt = b_r;
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    acc_nxt = acc_r;
    n_nxt = n_r;
    res_nxt = res_r;
    len_nxt = len_r;
    rem_nxt = rem_r;
    sh_nxt = sh_r;
    quot_nxt = quot_r;
    dir_nxt = dir_r;
    u_nxt = u_r;
    v_nxt = v_r;
    corf_nxt = corf_r;
    off_nxt = off_r;
    out_valid_nxt = out_valid_r;
    out_type_nxt = out_type_r;
    out_last_nxt = out_last_r;
    out_pos_nxt = out_pos_r;
    out_c_nxt = out_c_r;
    mul_a = '0;
    mul_b = '0;
    nsq = ph_r ? 4'd2 : 4'd3;
    bitv = 64'h4000_0000_0000_0000 >> {it_r, 1'b0};
    sum_rb = res_r + bitv;
    num = {1'b0, mag_r[k_r][30:0], 30'b0} + {31'b0, len_r[31:1]};
    t = {rem_r, sh_r[30]};
    ge = (t >= {1'b0, len_r});
    qv = (len_r == 32'd0) ? 31'd0 : {quot_r[29:0], ge};
    qs = neg_r[k_r] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    ax = dir_r[0][31] ? -dir_r[0] : dir_r[0];
    s0 = '0;
    s1 = '0;
    j3 = 3'(cnt_r - 4'd1);
    j2 = j3[1:0];
    half = -($signed({{32{u_r[j2][31]}}, u_r[j2]}) <<< 29);
    c1 = rnd30(half + prod64);
    c2 = rnd30(half - prod64);
    load = !out_valid_r || out_ch.ready;
    ci = (rec_r < 4'd3) ? rec_r[1:0] : 2'(rec_r - 4'd3);
    obase = {1'b0, ci, 1'b0} + {2'b0, ci};
    tr = rec_r - 4'd6;
    ts = tr[2:1];
    tn = (ts == 2'd2) ? 2'd0 : 2'(ts + 2'd1);
    base = start_r + vcount_r;
    for (int i = 0; i < 3; i++) begin
      dd[i] = $signed({b_r[i][31], b_r[i]}) - $signed({a_r[i][31], a_r[i]});
      dm[i] = dd[i][32] ? 33'(-dd[i]) : 33'(dd[i]);
    end

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt[0] = in_ch.a_x; a_nxt[1] = in_ch.a_y; a_nxt[2] = in_ch.a_z;
          b_nxt[0] = in_ch.b_x; b_nxt[1] = in_ch.b_y; b_nxt[2] = in_ch.b_z;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          mag_nxt[i] = dm[i][31:0];
          neg_nxt[i] = dd[i][32];
        end
        ph_nxt = 1'b0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        acc_nxt = '0;
        cnt_nxt = '0;
        if (mmax == 32'd0) begin
          state_nxt = S_IDLE;
        end else if (mmax[31]) begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
          state_nxt = S_SQ;
        end else if (mmax[30]) begin
          state_nxt = S_SQ;
        end else begin
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] << 1;
        end
      end
      S_SQ: begin
        if (cnt_r < nsq) begin
          mul_a = {1'b0, mag_r[cnt_r[1:0]]};
          mul_b = {1'b0, mag_r[cnt_r[1:0]]};
        end
        if (cnt_r != 4'd0) acc_nxt = acc_r + prod64;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == nsq) begin
          n_nxt = acc_r + prod64;
          res_nxt = '0;
          it_nxt = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (n_r >= sum_rb) begin
          n_nxt = n_r - sum_rb;
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd31) begin
          len_nxt = res_nxt[31:0];
          k_nxt = '0;
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        rem_nxt = {1'b0, num[61:31]};
        sh_nxt = num[30:0];
        quot_nxt = '0;
        it_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? 32'(t - {1'b0, len_r}) : t[31:0];
        sh_nxt = sh_r << 1;
        quot_nxt = {quot_r[29:0], ge};
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd30) begin
          k_nxt = k_r + 2'd1;
          state_nxt = S_DIVI;
          if (!ph_r) begin
            dir_nxt[k_r] = qs;
            if (k_r == 2'd2) state_nxt = S_AXIS;
          end else begin
            if (k_r == 2'd0) u_nxt[yaxis_r ? 0 : 1] = qs;
            else u_nxt[2] = qs;
            if (k_r == 2'd1) begin
              cnt_nxt = '0;
              state_nxt = S_CROSS;
            end
          end
        end
      end
      S_AXIS: begin
        yaxis_nxt = (ax >= $signed(THRESH_09));
        s0 = yaxis_nxt ? -dir_r[2] : dir_r[2];
        s1 = yaxis_nxt ? dir_r[0] : -dir_r[1];
        mag_nxt[0] = s0[31] ? 32'(-s0) : 32'(s0);
        mag_nxt[1] = s1[31] ? 32'(-s1) : 32'(s1);
        neg_nxt[0] = s0[31];
        neg_nxt[1] = s1[31];
        for (int i = 0; i < 3; i++) u_nxt[i] = '0;
        ph_nxt = 1'b1;
        acc_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_SQ;
      end
      S_CROSS: begin
        case (cnt_r[2:0])
          3'd0: begin mul_a = 33'(dir_r[1]); mul_b = 33'(u_r[2]); end
          3'd1: begin mul_a = 33'(dir_r[2]); mul_b = 33'(u_r[1]); end
          3'd2: begin mul_a = 33'(dir_r[2]); mul_b = 33'(u_r[0]); end
          3'd3: begin mul_a = 33'(dir_r[0]); mul_b = 33'(u_r[2]); end
          3'd4: begin mul_a = 33'(dir_r[0]); mul_b = 33'(u_r[1]); end
          3'd5: begin mul_a = 33'(dir_r[1]); mul_b = 33'(u_r[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_r != 4'd0) begin
          if (!j3[0]) acc_nxt = prod64;
          else v_nxt[j3[2:1]] = 32'(rnd30($signed(acc_r) - prod64));
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd6) begin
          cnt_nxt = '0;
          state_nxt = S_CORN;
        end
      end
      S_CORN: begin
        if (cnt_r < 4'd3) begin
          mul_a = 33'(v_r[cnt_r[1:0]]);
          mul_b = K_0866;
        end
        if (cnt_r != 4'd0) begin
          corf_nxt[{2'b0, j2}] = u_r[j2];
          corf_nxt[{2'b0, j2} + 4'd3] = 32'(c1);
          corf_nxt[{2'b0, j2} + 4'd6] = 32'(c2);
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd3) begin
          cnt_nxt = '0;
          state_nxt = S_OFF;
        end
      end
      S_OFF: begin
        if (cnt_r < 4'd9) begin
          mul_a = {2'b0, radius_r};
          mul_b = 33'(corf_r[cnt_r]);
        end
        if (cnt_r != 4'd0) off_nxt[cnt_r - 4'd1] = 32'(rnd30(prod64));
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd9) begin
          rec_nxt = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt = (rec_r == NUM_REC - 4'd1);
          if (rec_r < 4'd6) begin
            out_type_nxt = 1'b0;
            for (int c = 0; c < 3; c++) begin
              out_pos_nxt[c] = ((rec_r < 4'd3) ? a_r[c] : b_r[c]) +
                               $signed(off_r[obase + 4'(c)]);
              out_c_nxt[c] = '0;
            end
          end else begin
            out_type_nxt = 1'b1;
            for (int c = 0; c < 3; c++) out_pos_nxt[c] = '0;
            out_c_nxt[0] = base + 32'(ts);
            if (!tr[0]) begin
              out_c_nxt[1] = base + 32'(tn);
              out_c_nxt[2] = base + 32'd3 + 32'(tn);
            end else begin
              out_c_nxt[1] = base + 32'd3 + 32'(tn);
              out_c_nxt[2] = base + 32'd3 + 32'(ts);
            end
          end
          rec_nxt = rec_r + 4'd1;
          if (rec_r == NUM_REC - 4'd1) begin
            vcount_nxt = vcount_r + 32'd6;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      it_r <= '0;
      k_r <= '0;
      ph_r <= 1'b0;
      rec_r <= '0;
      vcount_r <= '0;
      out_valid_r <= 1'b0;
      radius_r <= RADIUS_RST;
      start_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      it_r <= it_nxt;
      k_r <= k_nxt;
      ph_r <= ph_nxt;
      rec_r <= rec_nxt;
      vcount_r <= vcount_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        if (cfg_ch.index == CFG_RADIUS) radius_r <= cfg_ch.data[30:0];
        else if (cfg_ch.index == CFG_START) start_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    yaxis_r <= yaxis_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    n_r <= n_nxt;
    res_r <= res_nxt;
    len_r <= len_nxt;
    rem_r <= rem_nxt;
    sh_r <= sh_nxt;
    quot_r <= quot_nxt;
    dir_r <= dir_nxt;
    u_r <= u_nxt;
    v_r <= v_nxt;
    corf_r <= corf_nxt;
    off_r <= off_nxt;
    out_type_r <= out_type_nxt;
    out_last_r <= out_last_nxt;
    out_pos_r <= out_pos_nxt;
    out_c_r <= out_c_nxt;
  end

  a_accept_diff: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_DIFF)
    else $error("accepted segment did not start");

  a_vcount_step: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r != $past(vcount_r) |-> vcount_r == $past(vcount_r) + 32'd6)
    else $error("vertex counter moved by other than six");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.last) &&
      $stable(out_ch.record_type) && $stable(out_ch.pos_x) && $stable(out_ch.corner0))
    else $error("record changed while stalled");

endmodule
